// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// a implies b in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ===== src/lrce_pkg.sv =====
// types, constants and color expansion helpers for the led ring color easer
// no dependencies
`default_nettype none
package lrce_pkg;

	localparam int MAX_LEDS = 24;
	localparam int IDX_W = 5;

	localparam logic [1:0] OP_PALETTE  = 2'd0;
	localparam logic [1:0] OP_PULSE    = 2'd1;
	localparam logic [1:0] OP_TICK     = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam logic [13:0] CEIL_Q16       = 14'd10486;
	localparam logic [15:0] PULSE_GAIN_Q16 = 16'd58982;
	localparam logic [11:0] EASE_Q16       = 12'd3932;
	localparam logic [14:0] DECAY_Q24      = 15'd26844;
	localparam logic [31:0] DECAY_CLEAR_MS = 32'd625;
	localparam logic [15:0] PULSE_FLOOR    = 16'd132;
	localparam logic [31:0] MIN_TICK_MS    = 32'd33;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] color;
		logic        palette_last;
		logic [15:0] brightness;
		logic [15:0] pulse_level;
		logic [31:0] now_ms;
	} in_t;

	typedef struct packed {
		logic [4:0] led_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_last;
	} out_t;

	typedef struct packed {
		logic [4:0] led_count;
		logic       ring_enabled;
	} cfg_t;

	// v*255*256/31 as v*2105 + floor(v*25/31), reciprocal with one correction
	function automatic logic [15:0] expand5(logic [4:0] v);
		logic [9:0]  y;
		logic [17:0] t;
		logic [4:0]  q;
		logic [9:0]  r;
		y = 10'(v) * 10'd25;
		t = 18'(y) * 18'd132;
		q = t[16:12];
		r = y - 10'(q) * 10'd31;
		if (r >= 10'd31) q = q + 5'd1;
		return 16'(v) * 16'd2105 + 16'(q);
	endfunction

	// v*255*256/63 as v*1036 + floor(v*12/63)
	function automatic logic [15:0] expand6(logic [5:0] v);
		logic [9:0]  y;
		logic [16:0] t;
		logic [3:0]  q;
		logic [9:0]  r;
		y = 10'(v) * 10'd12;
		t = 17'(y) * 17'd65;
		q = t[15:12];
		r = y - 10'(q) * 10'd63;
		if (r >= 10'd63) q = q + 4'd1;
		return 16'(v) * 16'd1036 + 16'(q);
	endfunction

endpackage
`default_nettype wire

// ===== src/lrce_front.sv =====
// front end: accepts input transactions, drops unknown operations, queues the rest
// depends on lrce_pkg
`default_nettype none
module lrce_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire lrce_pkg::in_t in_item,
	output logic               cmd_valid,
	output lrce_pkg::in_t      cmd,
	input  wire logic          cmd_pop
);
	import lrce_pkg::*;

	in_t        slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       acc;
	logic       keep;

	assign full = (cnt_q == 2'd2);
	assign acc = push && !full;
	assign keep = acc && (in_item.operation != OP_RESERVED);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (keep) slot_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (keep) wr_q <= !wr_q;
			if (cmd_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(keep) - 2'(cmd_pop);
		end
	end

endmodule
`default_nettype wire

// ===== src/lrce_engine.sv =====
// back end: palette closing, pulse tracking, tick decay, easing and frame output
// depends on lrce_pkg
`default_nettype none
module lrce_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lrce_pkg::cfg_t cfg,
	input  wire logic           cmd_valid,
	input  wire lrce_pkg::in_t  cmd,
	output logic                cmd_pop,
	output logic                empty,
	input  wire logic           pop,
	output lrce_pkg::out_t      out_item
);
	import lrce_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CLOSE, S_DEC1, S_DEC2, S_LVL1, S_LVL2, S_EASE, S_DRIVE, S_EMIT
	} state_t;

	state_t      state_q;
	logic [15:0] pal_q [MAX_LEDS];
	logic [15:0] tgt_q [MAX_LEDS][3];
	logic [15:0] cur_q [MAX_LEDS][3];
	logic [4:0]  fill_q;
	logic [4:0]  n_q;
	logic [4:0]  k_q;
	logic [4:0]  i_q;
	logic [1:0]  j_q;
	logic [15:0] base_q;
	logic [15:0] pulse_q;
	logic [31:0] last_q;
	logic [9:0]  dt_q;
	logic        clr_q;
	logic [25:0] pd_q;
	logic [16:0] g_q;
	logic [13:0] lvl_q;
	logic [15:0] e_q;
	logic [7:0]  byte_q [3];
	logic        out_v_q;
	out_t        out_q;

	logic [4:0]  m;
	logic [4:0]  fill_new;
	logic [31:0] dt;
	logic [15:0] pc;
	logic [40:0] dec_full;
	logic [15:0] p_new;
	logic [31:0] gain;
	logic [30:0] lvl_full;
	logic [15:0] cu;
	logic [15:0] tg;
	logic [15:0] diff;
	logic [27:0] ed;
	logic [15:0] eased;
	logic [29:0] drv;
	logic        out_free;

	assign m = (cfg.led_count > 5'(MAX_LEDS)) ? 5'(MAX_LEDS) : cfg.led_count;
	assign fill_new = (fill_q < 5'(MAX_LEDS)) ? fill_q + 5'd1 : fill_q;
	assign dt = cmd.now_ms - last_q;
	assign pc = pal_q[k_q];
	assign dec_full = 41'(pd_q) * 41'(DECAY_Q24);
	assign gain = 32'(pulse_q) * 32'(PULSE_GAIN_Q16);
	assign lvl_full = 31'(g_q) * 31'(CEIL_Q16);
	assign cu = cur_q[i_q][j_q];
	assign tg = tgt_q[i_q][j_q];
	assign diff = (tg >= cu) ? tg - cu : cu - tg;
	assign ed = 28'(diff) * 28'(EASE_Q16);
	assign eased = (tg >= cu) ? cu + 16'(ed[27:16]) : cu - 16'(ed[27:16]);
	assign drv = 30'(e_q) * 30'(lvl_q);
	assign out_free = !out_v_q || pop;
	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;
	assign empty = !out_v_q;
	assign out_item = out_q;

	always_comb begin
		p_new = clr_q ? 16'd0 : pulse_q - dec_full[39:24];
		if (p_new < PULSE_FLOOR) p_new = 16'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.operation == OP_PALETTE && fill_q < 5'(MAX_LEDS))
			pal_q[fill_q] <= cmd.color;
		if (state_q == S_DEC1) pd_q <= 26'(pulse_q) * 26'(dt_q);
		if (state_q == S_LVL1) g_q <= 17'(base_q) + 17'(gain[31:16]);
		if (state_q == S_EASE) e_q <= eased;
		if (state_q == S_DRIVE) byte_q[j_q] <= {2'b00, drv[29:24]};
		if (state_q == S_EMIT && out_free) begin
			out_q.led_index <= i_q;
			out_q.red <= byte_q[0];
			out_q.green <= byte_q[1];
			out_q.blue <= byte_q[2];
			out_q.frame_last <= (i_q + 5'd1 == m);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int a = 0; a < MAX_LEDS; a++) begin
				for (int b = 0; b < 3; b++) begin
					tgt_q[a][b] <= 16'd0;
					cur_q[a][b] <= 16'd0;
				end
			end
			fill_q <= 5'd0;
			n_q <= 5'd0;
			k_q <= 5'd0;
			i_q <= 5'd0;
			j_q <= 2'd0;
			base_q <= 16'd0;
			pulse_q <= 16'd0;
			last_q <= 32'd0;
			dt_q <= 10'd0;
			clr_q <= 1'b0;
			lvl_q <= 14'd0;
			out_v_q <= 1'b0;
		end else begin
			// in S_EMIT the output register is refilled below
			if (pop && out_v_q && state_q != S_EMIT) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.operation)
							OP_PALETTE: begin
								if (cmd.palette_last) begin
									base_q <= cmd.brightness;
									fill_q <= 5'd0;
									n_q <= fill_new;
									k_q <= 5'd0;
									i_q <= 5'd0;
									if (m != 5'd0) state_q <= S_CLOSE;
								end else begin
									fill_q <= fill_new;
								end
							end
							OP_PULSE: begin
								if (cmd.pulse_level > pulse_q) pulse_q <= cmd.pulse_level;
							end
							OP_TICK: begin
								if (cfg.ring_enabled && dt >= MIN_TICK_MS) begin
									last_q <= cmd.now_ms;
									dt_q <= dt[9:0];
									clr_q <= (dt >= DECAY_CLEAR_MS);
									state_q <= S_DEC1;
								end
							end
							default: ;
						endcase
					end
				end
				S_CLOSE: begin
					tgt_q[i_q][0] <= expand5(pc[15:11]);
					tgt_q[i_q][1] <= expand6(pc[10:5]);
					tgt_q[i_q][2] <= expand5(pc[4:0]);
					k_q <= (k_q + 5'd1 == n_q) ? 5'd0 : k_q + 5'd1;
					i_q <= i_q + 5'd1;
					if (i_q + 5'd1 == m) state_q <= S_IDLE;
				end
				S_DEC1: state_q <= S_DEC2;
				S_DEC2: begin
					pulse_q <= p_new;
					state_q <= S_LVL1;
				end
				S_LVL1: state_q <= S_LVL2;
				S_LVL2: begin
					lvl_q <= (lvl_full[30:16] > 15'(CEIL_Q16)) ? CEIL_Q16 : lvl_full[29:16];
					i_q <= 5'd0;
					j_q <= 2'd0;
					state_q <= (m == 5'd0) ? S_IDLE : S_EASE;
				end
				S_EASE: begin
					cur_q[i_q][j_q] <= eased;
					state_q <= S_DRIVE;
				end
				S_DRIVE: begin
					if (j_q == 2'd2) begin
						state_q <= S_EMIT;
					end else begin
						j_q <= j_q + 2'd1;
						state_q <= S_EASE;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						j_q <= 2'd0;
						i_q <= i_q + 5'd1;
						state_q <= (i_q + 5'd1 == m) ? S_IDLE : S_EASE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/led_ring_color_easer_unit.sv =====
// led ring color easer: eases a ring of rgb leds toward a palette
// Input is a queue: a transaction is taken when push is high and full is low.
// Operations: palette entry, pulse request, time tick; unknown codes are dropped.
// Results are a queue: while empty is low the oldest result is on out_item and
// it is taken when pop is high. A two-entry command queue parts the front end
// from the engine, and a single output register parts the engine from the sink.
// Palette entries and pulses are handled in S_IDLE; closing a palette visits
// S_CLOSE once per led. An accepted tick runs decay and level math (S_DEC1,
// S_DEC2, S_LVL1, S_LVL2), then per led eases and scales one channel at a
// time (S_EASE, S_DRIVE), then loads the output register (S_EMIT), using the
// single shared ease and drive multipliers.
// If the sink stalls the engine waits with the next led and the command queue
// fills, then full rises.
// Reset clears targets, current colors, levels and the tick time, and sets
// led_count to 24 and ring_enabled to 1. Registers: led_count at 0, ring_enabled at 4.
// depends on lrce_pkg, lrce_front, lrce_engine, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module led_ring_color_easer_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire lrce_pkg::in_t in_item,
	output logic               empty,
	input  wire logic          pop,
	output lrce_pkg::out_t     out_item,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import lrce_pkg::*;

	localparam logic REG_LED_COUNT = 1'b0;
	localparam logic REG_ENABLED   = 1'b1;

	cfg_t cfg_q;
	logic cmd_valid;
	in_t  cmd;
	logic cmd_pop;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_count <= 5'd24;
			cfg_q.ring_enabled <= 1'b1;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_LED_COUNT: cfg_q.led_count <= pwdata[4:0];
				REG_ENABLED:   cfg_q.ring_enabled <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LED_COUNT: prdata = {27'd0, cfg_q.led_count};
			REG_ENABLED:   prdata = {31'd0, cfg_q.ring_enabled};
			default:       prdata = 32'd0;
		endcase
	end

	lrce_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	lrce_engine u_engine (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_pop(cmd_pop), .empty(empty), .pop(pop), .out_item(out_item)
	);

	`ASSERT_IMPLY(a_pop_has_cmd, clk, arst_n, cmd_pop, cmd_valid)
	`ASSERT_IMPLY(a_index_range, clk, arst_n, !empty, out_item.led_index < 5'(MAX_LEDS))
	`ASSERT_NEXT(a_full_holds, clk, arst_n, full && !cmd_pop, full)

endmodule
`default_nettype wire
